// ===== rtl/sred_pkg.sv =====
// ----------------------------------------------------------------------------
// sred_pkg
// Types, constants and command structs for the SRED drop decision block.
// ----------------------------------------------------------------------------
`default_nettype none

package sred_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam logic [2:0] VERDICT_ENQUEUE     = 3'd0;
    localparam logic [2:0] VERDICT_MARK_EARLY  = 3'd1;
    localparam logic [2:0] VERDICT_MARK_FORCED = 3'd2;
    localparam logic [2:0] VERDICT_DROP_EARLY  = 3'd3;
    localparam logic [2:0] VERDICT_DROP_FORCED = 3'd4;

    localparam logic [2:0] REG_DROP_LIMIT   = 3'd0;
    localparam logic [2:0] REG_MAX_DROP     = 3'd1;
    localparam logic [2:0] REG_OVERWRITE    = 3'd2;
    localparam logic [2:0] REG_HIT_WEIGHT   = 3'd3;
    localparam logic [2:0] REG_USE_MARKING  = 3'd4;
    localparam logic [2:0] REG_HARD_DROP    = 3'd5;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic [31:0] flow_hash;
        logic [19:0] queue_level;
        logic        ecn_capable;
        logic [9:0]  rand_slot;
        logic [15:0] rand_overwrite;
        logic [15:0] rand_drop;
    } sred_in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        zombie_hit;
        logic [16:0] drop_prob;
        logic [24:0] hit_rate;
    } sred_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EWMA,
        ST_SQR,
        ST_DIV1_GO,
        ST_DIV1,
        ST_HIT,
        ST_DIV2_GO,
        ST_DIV2,
        ST_FIN,
        ST_DONE
    } sred_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic ewma;
        logic square;
        logic div1_start;
        logic hit_mul;
        logic div2_start;
        logic finish;
    } sred_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic need_div1;
        logic need_div2;
    } sred_status_t;

endpackage

`default_nettype wire

// ===== rtl/sred_ram.sv =====
// ----------------------------------------------------------------------------
// sred_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sred_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== rtl/sred_div.sv =====
// ----------------------------------------------------------------------------
// sred_div
// Restoring divider, unsigned 64 / 50 bits, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sred_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [49:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic [63:0] q_reg, q_next;
    logic [50:0] r_reg, r_next;
    logic [49:0] dv_reg, dv_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        logic [50:0] r;
        logic [63:0] q;
        r = r_reg;
        q = q_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            dv_next   = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r = {r[49:0], q[63]};
                q = {q[62:0], 1'b0};
                if (r >= {1'b0, dv_reg})
                begin
                    r    = r - {1'b0, dv_reg};
                    q[0] = 1'b1;
                end
            end
            q_next   = q;
            r_next   = r;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        dv_reg <= dv_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== rtl/sred_datapath.sv =====
// ----------------------------------------------------------------------------
// sred_datapath
// Flow table, hit-rate EWMA, drop probability and verdict datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sred_datapath #(
    parameter int TABLE_ENTRIES = sred_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sred_pkg::sred_in_t    item,
    input  wire sred_pkg::sred_cmd_t   cmd,
    output sred_pkg::sred_status_t     status,
    input  wire logic [19:0]           drop_limit,
    input  wire logic [16:0]           max_drop_prob,
    input  wire logic [16:0]           overwrite_prob,
    input  wire logic [24:0]           hit_weight,
    input  wire logic                  use_marking,
    input  wire logic                  hard_drop_above_limit,
    output sred_pkg::sred_out_t        result,
    output logic                       result_valid
);
    import sred_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int SW = 10;

    sred_in_t        in_reg;
    logic [AW:0]     fill_reg;
    logic [24:0]     p_reg;
    logic            filling_reg;
    logic            hit_reg;
    logic [AW-1:0]   addr_reg;
    logic [63:0]     z_reg;
    logic [49:0]     psq_reg;
    logic [18:0]     s_reg;
    logic [63:0]     num_reg;
    sred_out_t       res_reg;
    logic            rv_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [31:0]     ram_rdata;

    logic            div_start;
    logic [63:0]     div_dividend;
    logic [49:0]     div_divisor;
    logic [63:0]     div_q;
    logic            div_done;

    logic [AW-1:0]   slot_sel;
    logic [SW:0]     slot_ext;
    logic            full;

    assign full = (fill_reg == (AW+1)'(TABLE_ENTRIES));

    always_comb
    begin
        slot_ext = {1'b0, item.rand_slot};
        if ({{(AW+1){1'b0}}, slot_ext} >= (AW+SW+2)'(TABLE_ENTRIES))
        begin
            slot_sel = AW'(TABLE_ENTRIES - 1);
        end
        else
        begin
            slot_sel = AW'(slot_ext);
        end
    end

    // table port: write on fill at load, read on load, overwrite at compare
    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = addr_reg;
        if (cmd.load)
        begin
            ram_addr = full ? slot_sel : fill_reg[AW-1:0];
            ram_we   = !full;
        end
        else if (cmd.compare && !filling_reg && ram_rdata != in_reg.flow_hash
                 && ({1'b0, in_reg.rand_overwrite} < overwrite_prob))
        begin
            ram_we = 1'b1;
        end
    end

    sred_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.load ? item.flow_hash : in_reg.flow_hash),
        .rdata (ram_rdata)
    );

    logic [24:0] a_sat;
    logic [16:0] pmax_sat;
    assign a_sat    = (hit_weight > ONE_Q24) ? ONE_Q24 : hit_weight;
    assign pmax_sat = (max_drop_prob > 17'd65536) ? 17'd65536 : max_drop_prob;

    logic [49:0] ewma_sum;
    logic [24:0] p_new;
    always_comb
    begin
        ewma_sum = 50'(ONE_Q24 - a_sat) * 50'(p_reg)
                 + (hit_reg ? {a_sat, 24'd0} : 50'd0) + 50'(24'h80_0000);
        p_new = ewma_sum[48:24];
    end

    logic [21:0] lvl3;
    logic [22:0] lvl6;
    assign lvl3 = 22'(in_reg.queue_level) * 22'd3;
    assign lvl6 = 23'(in_reg.queue_level) * 23'd6;

    always_comb
    begin
        div_start    = cmd.div1_start || cmd.div2_start;
        div_dividend = cmd.div1_start ? {1'b0, s_reg, 44'd0} : num_reg;
        div_divisor  = cmd.div1_start ? psq_reg : 50'(p_reg);
    end

    sred_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    logic [63:0] d_final;
    logic        early;
    always_comb
    begin
        d_final = (z_reg > 64'(ONE_Q30)) ? 64'(ONE_Q30) : z_reg;
        early   = ({34'd0, in_reg.rand_drop, 14'd0} < d_final);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            p_reg    <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            rv_reg <= cmd.finish;
            if (cmd.load && !full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.ewma)
            begin
                p_reg <= p_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg      <= item;
            filling_reg <= !full;
            addr_reg    <= full ? slot_sel : fill_reg[AW-1:0];
        end
        if (cmd.compare)
        begin
            hit_reg <= !filling_reg && (ram_rdata == in_reg.flow_hash);
            if (3'(lvl3 >= 22'(drop_limit)) != 3'd0)
            begin
                s_reg <= {pmax_sat, 2'b00};
            end
            else if (lvl6 >= 23'(drop_limit))
            begin
                s_reg <= 19'(pmax_sat);
            end
            else
            begin
                s_reg <= '0;
            end
        end
        if (cmd.square)
        begin
            psq_reg <= 50'(p_reg) * 50'(p_reg);
            z_reg   <= {33'd0, s_reg, 12'd0};
        end
        if (div_done)
        begin
            z_reg <= div_q;
        end
        if (cmd.hit_mul)
        begin
            // z < 2^31 here so the product fits
            num_reg <= 64'(z_reg[31:0]) * 64'({7'd0, p_reg} + 32'(ONE_Q24));
        end
        if (cmd.finish)
        begin
            res_reg.zombie_hit <= hit_reg;
            res_reg.hit_rate   <= p_reg;
            res_reg.drop_prob  <= 17'((d_final + 64'd8192) >> 14);
            if (in_reg.queue_level >= drop_limit)
            begin
                res_reg.verdict <= (hard_drop_above_limit || !use_marking
                                    || !in_reg.ecn_capable)
                                   ? VERDICT_DROP_FORCED : VERDICT_MARK_FORCED;
            end
            else if (early)
            begin
                res_reg.verdict <= (use_marking && in_reg.ecn_capable)
                                   ? VERDICT_MARK_EARLY : VERDICT_DROP_EARLY;
            end
            else
            begin
                res_reg.verdict <= VERDICT_ENQUEUE;
            end
        end
    end

    always_comb
    begin
        status.div_done  = div_done;
        status.need_div1 = (p_reg >= 25'd65536);
        status.need_div2 = hit_reg && (p_reg != 25'd0);
    end

    assign result       = res_reg;
    assign result_valid = rv_reg;

endmodule

`default_nettype wire

// ===== rtl/sred_ctrl.sv =====
// ----------------------------------------------------------------------------
// sred_ctrl
// Sequencer for one packet: table access, EWMA, scaling divides, verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module sred_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire sred_pkg::sred_status_t status,
    output sred_pkg::sred_cmd_t        cmd,
    output logic                       busy
);
    import sred_pkg::*;

    sred_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_EWMA;
            end
            ST_EWMA:
            begin
                cmd.ewma   = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.square = 1'b1;
                if (status.need_div1)
                begin
                    state_next = ST_DIV1_GO;
                end
                else
                begin
                    state_next = ST_HIT;
                end
            end
            ST_DIV1_GO:
            begin
                // P^2 is registered by now
                cmd.div1_start = 1'b1;
                state_next     = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (status.div_done)
                begin
                    state_next = ST_HIT;
                end
            end
            ST_HIT:
            begin
                if (status.need_div2)
                begin
                    cmd.hit_mul = 1'b1;
                    state_next  = ST_DIV2_GO;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DIV2_GO:
            begin
                cmd.div2_start = 1'b1;
                state_next     = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sred_drop_decision.sv =====
// ----------------------------------------------------------------------------
// sred_drop_decision
// done follows the read, compare, EWMA, square and hit states; the flow-count
// and hit divides each add 16 radix-16 steps plus their start and done states.
// One packet at a time: busy stays high until done, next start the cycle after.
// Result is shown for one cycle with done; the receiver cannot stall.
// Reset clears fill count and hit rate, presets config; table fills before use.
// ----------------------------------------------------------------------------
`default_nettype none

module sred_drop_decision #(
    parameter int TABLE_ENTRIES = sred_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire sred_pkg::sred_in_t  item,
    output logic                     done,
    output sred_pkg::sred_out_t      result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import sred_pkg::*;

    logic [19:0] drop_limit_reg;
    logic [16:0] max_drop_reg;
    logic [16:0] overwrite_reg;
    logic [24:0] hit_weight_reg;
    logic        use_marking_reg;
    logic        hard_drop_reg;

    sred_cmd_t    cmd;
    sred_status_t status;
    logic         ctrl_busy;

    assign cfg_ready = 1'b1;
    assign busy      = ctrl_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_limit_reg  <= 20'd25;
            max_drop_reg    <= 17'd9830;
            overwrite_reg   <= 17'd16384;
            hit_weight_reg  <= 25'd16777;
            use_marking_reg <= 1'b0;
            hard_drop_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DROP_LIMIT:  drop_limit_reg  <= cfg_data[19:0];
                REG_MAX_DROP:    max_drop_reg    <= cfg_data[16:0];
                REG_OVERWRITE:   overwrite_reg   <= cfg_data[16:0];
                REG_HIT_WEIGHT:  hit_weight_reg  <= cfg_data[24:0];
                REG_USE_MARKING: use_marking_reg <= cfg_data[0];
                REG_HARD_DROP:   hard_drop_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    sred_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (ctrl_busy)
    );

    sred_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .item                  (item),
        .cmd                   (cmd),
        .status                (status),
        .drop_limit            (drop_limit_reg),
        .max_drop_prob         (max_drop_reg),
        .overwrite_prob        (overwrite_reg),
        .hit_weight            (hit_weight_reg),
        .use_marking           (use_marking_reg),
        .hard_drop_above_limit (hard_drop_reg),
        .result                (result),
        .result_valid          (done)
    );

endmodule

`default_nettype wire
